[rtl/tisp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tisp_pkg: shared types and constants of the terminal input parser
// Item and result formats, parser modes, key codes and queue sizing.
// ----------------------------------------------------------------------------
package tisp_pkg;

   // CSI parameter storage
   localparam int VALUE_WIDTH = 16;
   localparam int KEPT_PARAMS = 3;
   localparam int CNT_W       = $clog2(KEPT_PARAMS + 1);
   localparam int IDX_W       = (KEPT_PARAMS > 1) ? $clog2(KEPT_PARAMS) : 1;
   localparam int PROD_W      = VALUE_WIDTH + 4;

   // queue between front and back (power of two)
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // result kinds
   localparam logic [1:0] KIND_KEY       = 2'd0;
   localparam logic [1:0] KIND_MOUSE     = 2'd1;
   localparam logic [1:0] KIND_PASTE     = 2'd2;
   localparam logic [1:0] KIND_PASTE_END = 2'd3;

   // key codes
   localparam logic [4:0] KEY_CHAR   = 5'd0;
   localparam logic [4:0] KEY_ENTER  = 5'd1;
   localparam logic [4:0] KEY_TAB    = 5'd2;
   localparam logic [4:0] KEY_BSPACE = 5'd3;
   localparam logic [4:0] KEY_ESCAPE = 5'd4;
   localparam logic [4:0] KEY_UP     = 5'd5;
   localparam logic [4:0] KEY_DOWN   = 5'd6;
   localparam logic [4:0] KEY_LEFT   = 5'd7;
   localparam logic [4:0] KEY_RIGHT  = 5'd8;
   localparam logic [4:0] KEY_HOME   = 5'd9;
   localparam logic [4:0] KEY_END    = 5'd10;
   localparam logic [4:0] KEY_INSERT = 5'd11;
   localparam logic [4:0] KEY_DELETE = 5'd12;
   localparam logic [4:0] KEY_PGUP   = 5'd13;
   localparam logic [4:0] KEY_PGDN   = 5'd14;
   localparam logic [4:0] KEY_F1     = 5'd15;
   localparam logic [4:0] KEY_F2     = 5'd16;
   localparam logic [4:0] KEY_F3     = 5'd17;
   localparam logic [4:0] KEY_F4     = 5'd18;

   // modifier bits
   localparam logic [3:0] MOD_NONE = 4'd0;
   localparam logic [3:0] MOD_ALT  = 4'd2;
   localparam logic [3:0] MOD_CTRL = 4'd4;

   // mouse event types
   localparam logic [2:0] MOUSE_PRESS   = 3'd0;
   localparam logic [2:0] MOUSE_RELEASE = 3'd1;
   localparam logic [2:0] MOUSE_MOVE    = 3'd2;
   localparam logic [2:0] MOUSE_WHEEL_U = 3'd3;
   localparam logic [2:0] MOUSE_WHEEL_D = 3'd4;

   // bytes of interest
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_SS3   = 8'h4F;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QUES  = 8'h3F;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_HT    = 8'h09;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   // escape tick action
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef enum logic [2:0] {
      MODE_GROUND = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_CSI    = 3'd2,
      MODE_SS3    = 3'd3,
      MODE_PASTE  = 3'd4,
      MODE_UTF8   = 3'd5
   } mode_type;

   typedef struct packed {
      logic       action;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  key_code;
      logic [3:0]  modifiers;
      logic [20:0] codepoint;
      logic [2:0]  mouse_type;
      logic [1:0]  mouse_button;
      logic [15:0] mouse_x;
      logic [15:0] mouse_y;
      logic [7:0]  paste_byte;
      logic        last;
   } rsp_type;

   // one queue entry holds all results of one item
   typedef struct packed {
      logic    two;
      rsp_type r0;
      rsp_type r1;
   } entry_type;

endpackage
`default_nettype wire

[rtl/tisp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tisp_front: byte classifier and parser state
// Accepts one item a cycle while the result queue is not full, updates the parser state and pushes its results.
// ----------------------------------------------------------------------------
module tisp_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   output logic                   full,
   input  wire tisp_pkg::req_type req_item,
   input  wire                    q_full,
   output logic                   q_push,
   output tisp_pkg::entry_type    q_entry
);

   typedef struct packed {
      logic                 emit;
      tisp_pkg::rsp_type    rsp;
      tisp_pkg::mode_type   mode;
      logic                 load;
      logic [1:0]           left;
      logic [20:0]          value;
   } gnd_type;

   tisp_pkg::mode_type mode_ff, mode_in;
   logic [1:0]  left_ff, left_in;
   logic [20:0] uval_ff, uval_in;
   logic [tisp_pkg::VALUE_WIDTH-1:0] vals_ff [tisp_pkg::KEPT_PARAMS];
   logic [tisp_pkg::VALUE_WIDTH-1:0] vals_in [tisp_pkg::KEPT_PARAMS];
   logic [tisp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic started_ff, started_in, lt_ff, lt_in, priv_ff, priv_in;
   logic stop_ff, stop_in, ovf_ff, ovf_in;
   logic [2:0] psm_ff, psm_in;
   logic [7:0] win_ff [6];
   logic [7:0] win_in [6];
   logic [2:0] fill_ff, fill_in;
   logic accept;
   logic v0, v1;
   tisp_pkg::rsp_type e0, e1;

   function automatic tisp_pkg::rsp_type mk_key(input logic [4:0] code,
                                                input logic [3:0] mods,
                                                input logic [20:0] cp);
      tisp_pkg::rsp_type r;
      r           = '0;
      r.kind      = tisp_pkg::KIND_KEY;
      r.key_code  = code;
      r.modifiers = mods;
      r.codepoint = cp;
      return r;
   endfunction

   // ground-state handling of one byte
   function automatic gnd_type ground_fn(input logic [7:0] b);
      gnd_type g;
      g      = '0;
      g.mode = tisp_pkg::MODE_GROUND;
      if (b == tisp_pkg::CH_ESC) begin
         g.mode = tisp_pkg::MODE_ESC;
      end else if (b < 8'h20) begin
         g.emit = 1'b1;
         if (b == tisp_pkg::CH_CR || b == tisp_pkg::CH_LF) begin
            g.rsp = mk_key(tisp_pkg::KEY_ENTER, tisp_pkg::MOD_NONE, 21'd0);
         end else if (b == tisp_pkg::CH_HT) begin
            g.rsp = mk_key(tisp_pkg::KEY_TAB, tisp_pkg::MOD_NONE, 21'd0);
         end else if (b == tisp_pkg::CH_BS) begin
            g.rsp = mk_key(tisp_pkg::KEY_BSPACE, tisp_pkg::MOD_NONE, 21'd0);
         end else begin
            g.rsp = mk_key(tisp_pkg::KEY_CHAR, tisp_pkg::MOD_CTRL,
                           21'(b) + 21'h60);
         end
      end else if (b == tisp_pkg::CH_DEL) begin
         g.emit = 1'b1;
         g.rsp  = mk_key(tisp_pkg::KEY_BSPACE, tisp_pkg::MOD_NONE, 21'd0);
      end else if (b[7]) begin
         if (b[7:5] == 3'b110) begin
            g.load = 1'b1; g.left = 2'd1; g.value = {16'd0, b[4:0]};
         end else if (b[7:4] == 4'b1110) begin
            g.load = 1'b1; g.left = 2'd2; g.value = {17'd0, b[3:0]};
         end else if (b[7:3] == 5'b11110) begin
            g.load = 1'b1; g.left = 2'd3; g.value = {18'd0, b[2:0]};
         end
         if (g.load) begin
            g.mode = tisp_pkg::MODE_UTF8;
         end
      end else begin
         g.emit = 1'b1;
         g.rsp  = mk_key(tisp_pkg::KEY_CHAR, tisp_pkg::MOD_NONE, 21'(b));
      end
      return g;
   endfunction

   assign full   = q_full;
   assign accept = push && !q_full;

   // classify the beat and compute next state and results
   always_comb begin
      logic [7:0] b;
      gnd_type g;
      logic first;
      logic [tisp_pkg::IDX_W-1:0] idx;
      logic [tisp_pkg::PROD_W-1:0] prod;
      logic [tisp_pkg::VALUE_WIDTH-1:0] p0, raw, p1;
      logic [3:0] mods, mm;
      logic [7:0] nw [6];
      logic wmatch;
      b          = req_item.in_byte;
      g          = '0;
      mode_in    = mode_ff;
      left_in    = left_ff;
      uval_in    = uval_ff;
      vals_in    = vals_ff;
      cnt_in     = cnt_ff;
      started_in = started_ff;
      lt_in      = lt_ff;
      priv_in    = priv_ff;
      stop_in    = stop_ff;
      ovf_in     = ovf_ff;
      psm_in     = psm_ff;
      win_in     = win_ff;
      fill_in    = fill_ff;
      v0         = 1'b0;
      v1         = 1'b0;
      e0         = '0;
      e1         = '0;
      first      = !started_ff;
      idx        = cnt_ff[tisp_pkg::IDX_W-1:0];
      prod       = ({4'd0, vals_ff[idx]} << 3) + ({4'd0, vals_ff[idx]} << 1)
                   + tisp_pkg::PROD_W'(b[3:0]);
      p0         = lt_ff ? '0 : vals_ff[0];
      raw        = vals_ff[0];
      p1         = vals_ff[1];
      mods       = (p1 <= tisp_pkg::VALUE_WIDTH'(1)) ? 4'd0 : 4'(p1 - 1'b1);
      mm         = {1'b0, raw[4], raw[3], raw[2]};
      nw         = win_ff;
      nw[fill_ff] = b;
      wmatch     = nw[0] == tisp_pkg::CH_ESC && nw[1] == tisp_pkg::CH_LBRK &&
                   nw[2] == tisp_pkg::CH_TWO && nw[3] == tisp_pkg::CH_ZERO &&
                   nw[4] == tisp_pkg::CH_ONE && nw[5] == tisp_pkg::CH_TILDE;
      if (accept) begin
         if (req_item.action == tisp_pkg::ACT_TICK) begin
            // resolve a pending bare escape
            if (mode_ff == tisp_pkg::MODE_ESC) begin
               mode_in = tisp_pkg::MODE_GROUND;
               v0      = 1'b1;
               e0      = mk_key(tisp_pkg::KEY_ESCAPE, tisp_pkg::MOD_NONE, 21'd0);
            end
         end else begin
            unique case (mode_ff)
               tisp_pkg::MODE_ESC: begin
                  if (b == tisp_pkg::CH_LBRK) begin
                     vals_in    = '{default: '0};
                     cnt_in     = '0;
                     started_in = 1'b0;
                     lt_in      = 1'b0;
                     priv_in    = 1'b0;
                     stop_in    = 1'b0;
                     ovf_in     = 1'b0;
                     psm_in     = 3'd0;
                     mode_in    = tisp_pkg::MODE_CSI;
                  end else if (b == tisp_pkg::CH_SS3) begin
                     mode_in = tisp_pkg::MODE_SS3;
                  end else begin
                     mode_in = tisp_pkg::MODE_GROUND;
                     v0      = 1'b1;
                     if (b == tisp_pkg::CH_CR || b == tisp_pkg::CH_LF) begin
                        e0 = mk_key(tisp_pkg::KEY_ENTER, tisp_pkg::MOD_ALT, 21'd0);
                     end else if (b >= 8'h20 && b < 8'h7F) begin
                        e0 = mk_key(tisp_pkg::KEY_CHAR, tisp_pkg::MOD_ALT, 21'(b));
                     end else begin
                        // escape key, then the byte as in ground state
                        e0 = mk_key(tisp_pkg::KEY_ESCAPE, tisp_pkg::MOD_NONE, 21'd0);
                        g  = ground_fn(b);
                        mode_in = g.mode;
                        if (g.load) begin
                           left_in = g.left;
                           uval_in = g.value;
                        end
                        v1 = g.emit;
                        e1 = g.rsp;
                     end
                  end
               end
               tisp_pkg::MODE_CSI: begin
                  if ((b >= 8'h30 && b <= 8'h39) || b == tisp_pkg::CH_SEMI ||
                      b == tisp_pkg::CH_LT || b == tisp_pkg::CH_GT ||
                      b == tisp_pkg::CH_QUES || (b >= 8'h20 && b <= 8'h2F)) begin
                     // collect parameter or intermediate byte
                     started_in = 1'b1;
                     if (psm_ff < 3'd3 &&
                         b == ((psm_ff == 3'd0) ? tisp_pkg::CH_TWO : tisp_pkg::CH_ZERO)) begin
                        psm_in = psm_ff + 3'd1;
                     end else begin
                        psm_in = 3'd7;
                     end
                     if (b == tisp_pkg::CH_SEMI) begin
                        if (cnt_ff < tisp_pkg::CNT_W'(tisp_pkg::KEPT_PARAMS)) begin
                           cnt_in = cnt_ff + 1'b1;
                        end
                        stop_in = 1'b0;
                        ovf_in  = 1'b0;
                     end else if (b >= 8'h30 && b <= 8'h39) begin
                        if (!(stop_ff || ovf_ff) &&
                            cnt_ff < tisp_pkg::CNT_W'(tisp_pkg::KEPT_PARAMS)) begin
                           if (|prod[tisp_pkg::PROD_W-1:tisp_pkg::VALUE_WIDTH]) begin
                              ovf_in       = 1'b1;
                              vals_in[idx] = '0;
                           end else begin
                              vals_in[idx] = prod[tisp_pkg::VALUE_WIDTH-1:0];
                           end
                        end
                     end else if (first && b == tisp_pkg::CH_LT) begin
                        lt_in = 1'b1;
                     end else begin
                        if (first && (b == tisp_pkg::CH_GT || b == tisp_pkg::CH_QUES)) begin
                           priv_in = 1'b1;
                        end
                        stop_in = 1'b1;
                     end
                  end else if (b >= 8'h40 && b <= 8'h7E) begin
                     // final byte: dispatch the sequence
                     mode_in = tisp_pkg::MODE_GROUND;
                     if (lt_ff && (b == 8'h4D || b == 8'h6D)) begin
                        if (cnt_ff >= tisp_pkg::CNT_W'(2)) begin
                           v0            = 1'b1;
                           e0            = '0;
                           e0.kind       = tisp_pkg::KIND_MOUSE;
                           e0.modifiers  = mm;
                           e0.mouse_x    = 16'(vals_ff[1]);
                           e0.mouse_y    = 16'(vals_ff[2]);
                           if (raw[6] && raw[1:0] == 2'd0) begin
                              e0.mouse_type = tisp_pkg::MOUSE_WHEEL_U;
                           end else if (raw[6] && raw[1:0] == 2'd1) begin
                              e0.mouse_type = tisp_pkg::MOUSE_WHEEL_D;
                           end else begin
                              e0.mouse_button = raw[1:0];
                              if (raw[5]) begin
                                 e0.mouse_type = tisp_pkg::MOUSE_MOVE;
                              end else if (b == 8'h6D) begin
                                 e0.mouse_type = tisp_pkg::MOUSE_RELEASE;
                              end else begin
                                 e0.mouse_type = tisp_pkg::MOUSE_PRESS;
                              end
                           end
                        end
                     end else if (b == tisp_pkg::CH_TILDE && psm_ff == 3'd3) begin
                        mode_in = tisp_pkg::MODE_PASTE;
                        fill_in = 3'd0;
                     end else if (b == 8'h75) begin
                        v0 = 1'b1;
                        if (p0 == tisp_pkg::VALUE_WIDTH'(13)) begin
                           e0 = mk_key(tisp_pkg::KEY_ENTER, mods, 21'd0);
                        end else if (p0 == tisp_pkg::VALUE_WIDTH'(9)) begin
                           e0 = mk_key(tisp_pkg::KEY_TAB, mods, 21'd0);
                        end else if (p0 == tisp_pkg::VALUE_WIDTH'(127)) begin
                           e0 = mk_key(tisp_pkg::KEY_BSPACE, mods, 21'd0);
                        end else if (p0 == tisp_pkg::VALUE_WIDTH'(27)) begin
                           e0 = mk_key(tisp_pkg::KEY_ESCAPE, mods, 21'd0);
                        end else if (p0 >= tisp_pkg::VALUE_WIDTH'(32) &&
                                     p0 <= tisp_pkg::VALUE_WIDTH'(17'hFFFF)) begin
                           e0 = mk_key(tisp_pkg::KEY_CHAR, mods, 21'(p0));
                        end else begin
                           v0 = 1'b0;
                        end
                     end else if (!priv_ff) begin
                        v0 = 1'b1;
                        priority case (b)
                           8'h41: e0 = mk_key(tisp_pkg::KEY_UP, mods, 21'd0);
                           8'h42: e0 = mk_key(tisp_pkg::KEY_DOWN, mods, 21'd0);
                           8'h43: e0 = mk_key(tisp_pkg::KEY_RIGHT, mods, 21'd0);
                           8'h44: e0 = mk_key(tisp_pkg::KEY_LEFT, mods, 21'd0);
                           8'h48: e0 = mk_key(tisp_pkg::KEY_HOME, mods, 21'd0);
                           8'h46: e0 = mk_key(tisp_pkg::KEY_END, mods, 21'd0);
                           tisp_pkg::CH_TILDE: begin
                              if (p0 >= tisp_pkg::VALUE_WIDTH'(32)) begin
                                 v0 = 1'b0;
                              end else begin
                                 unique case (p0[4:0])
                                    5'd1: e0 = mk_key(tisp_pkg::KEY_HOME, mods, 21'd0);
                                    5'd2: e0 = mk_key(tisp_pkg::KEY_INSERT, mods, 21'd0);
                                    5'd3: e0 = mk_key(tisp_pkg::KEY_DELETE, mods, 21'd0);
                                    5'd4: e0 = mk_key(tisp_pkg::KEY_END, mods, 21'd0);
                                    5'd5: e0 = mk_key(tisp_pkg::KEY_PGUP, mods, 21'd0);
                                    5'd6: e0 = mk_key(tisp_pkg::KEY_PGDN, mods, 21'd0);
                                    5'd11, 5'd12, 5'd13, 5'd14, 5'd15:
                                       e0 = mk_key(p0[4:0] + 5'd4, mods, 21'd0);
                                    5'd17, 5'd18, 5'd19, 5'd20, 5'd21:
                                       e0 = mk_key(p0[4:0] + 5'd3, mods, 21'd0);
                                    5'd23, 5'd24:
                                       e0 = mk_key(p0[4:0] + 5'd2, mods, 21'd0);
                                    default: v0 = 1'b0;
                                 endcase
                              end
                           end
                           default: v0 = 1'b0;
                        endcase
                     end
                  end else begin
                     // abort the sequence and drop the byte
                     mode_in = tisp_pkg::MODE_GROUND;
                  end
               end
               tisp_pkg::MODE_SS3: begin
                  mode_in = tisp_pkg::MODE_GROUND;
                  v0      = 1'b1;
                  priority case (b)
                     8'h41: e0 = mk_key(tisp_pkg::KEY_UP, tisp_pkg::MOD_NONE, 21'd0);
                     8'h42: e0 = mk_key(tisp_pkg::KEY_DOWN, tisp_pkg::MOD_NONE, 21'd0);
                     8'h43: e0 = mk_key(tisp_pkg::KEY_RIGHT, tisp_pkg::MOD_NONE, 21'd0);
                     8'h44: e0 = mk_key(tisp_pkg::KEY_LEFT, tisp_pkg::MOD_NONE, 21'd0);
                     8'h48: e0 = mk_key(tisp_pkg::KEY_HOME, tisp_pkg::MOD_NONE, 21'd0);
                     8'h46: e0 = mk_key(tisp_pkg::KEY_END, tisp_pkg::MOD_NONE, 21'd0);
                     8'h50: e0 = mk_key(tisp_pkg::KEY_F1, tisp_pkg::MOD_NONE, 21'd0);
                     8'h51: e0 = mk_key(tisp_pkg::KEY_F2, tisp_pkg::MOD_NONE, 21'd0);
                     8'h52: e0 = mk_key(tisp_pkg::KEY_F3, tisp_pkg::MOD_NONE, 21'd0);
                     8'h53: e0 = mk_key(tisp_pkg::KEY_F4, tisp_pkg::MOD_NONE, 21'd0);
                     default: v0 = 1'b0;
                  endcase
               end
               tisp_pkg::MODE_PASTE: begin
                  // slide the six-byte window, watch for the end marker
                  if (fill_ff >= 3'd5) begin
                     v0 = 1'b1;
                     e0 = '0;
                     if (wmatch) begin
                        e0.kind = tisp_pkg::KIND_PASTE_END;
                        fill_in = 3'd0;
                        mode_in = tisp_pkg::MODE_GROUND;
                     end else begin
                        e0.kind       = tisp_pkg::KIND_PASTE;
                        e0.paste_byte = nw[0];
                        for (int i = 0; i < 5; i++) begin
                           win_in[i] = nw[i+1];
                        end
                        win_in[5] = nw[5];
                        fill_in   = 3'd5;
                     end
                  end else begin
                     win_in  = nw;
                     fill_in = fill_ff + 3'd1;
                  end
               end
               tisp_pkg::MODE_UTF8: begin
                  if (b[7:6] != 2'b10) begin
                     // broken sequence: restart in ground state
                     g       = ground_fn(b);
                     left_in = g.load ? g.left : 2'd0;
                     uval_in = g.load ? g.value : 21'd0;
                     mode_in = g.mode;
                     v0      = g.emit;
                     e0      = g.rsp;
                  end else begin
                     uval_in = {uval_ff[14:0], b[5:0]};
                     left_in = (left_ff > 2'd0) ? left_ff - 2'd1 : 2'd0;
                     if (left_ff <= 2'd1) begin
                        uval_in = 21'd0;
                        mode_in = tisp_pkg::MODE_GROUND;
                        v0      = {uval_ff[14:0], b[5:0]} != 21'd0;
                        e0      = mk_key(tisp_pkg::KEY_CHAR, tisp_pkg::MOD_NONE,
                                         {uval_ff[14:0], b[5:0]});
                     end
                  end
               end
               default: begin
                  g       = ground_fn(b);
                  mode_in = g.mode;
                  if (g.load) begin
                     left_in = g.left;
                     uval_in = g.value;
                  end
                  v0 = g.emit;
                  e0 = g.rsp;
               end
            endcase
         end
      end
      e0.last = !v1;
      e1.last = 1'b1;
   end

   assign q_push  = accept && v0;
   assign q_entry = '{two: v1, r0: e0, r1: e1};

   // hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= tisp_pkg::MODE_GROUND;
         left_ff    <= '0;
         uval_ff    <= '0;
         vals_ff    <= '{default: '0};
         cnt_ff     <= '0;
         started_ff <= 1'b0;
         lt_ff      <= 1'b0;
         priv_ff    <= 1'b0;
         stop_ff    <= 1'b0;
         ovf_ff     <= 1'b0;
         psm_ff     <= '0;
         fill_ff    <= '0;
      end else begin
         mode_ff    <= mode_in;
         left_ff    <= left_in;
         uval_ff    <= uval_in;
         vals_ff    <= vals_in;
         cnt_ff     <= cnt_in;
         started_ff <= started_in;
         lt_ff      <= lt_in;
         priv_ff    <= priv_in;
         stop_ff    <= stop_in;
         ovf_ff     <= ovf_in;
         psm_ff     <= psm_in;
         fill_ff    <= fill_in;
      end
   end

   // paste window carries data only
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule
`default_nettype wire

[rtl/tisp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tisp_queue: result entry queue
// Small register queue between the parser front and the output back.
// ----------------------------------------------------------------------------
module tisp_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   output logic                     full,
   input  wire tisp_pkg::entry_type wr_entry,
   input  wire                      pop,
   output logic                     empty,
   output tisp_pkg::entry_type      head
);

   tisp_pkg::entry_type mem_ff [tisp_pkg::QDEPTH];
   logic [tisp_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [tisp_pkg::QPTR_W:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full    = cnt_ff == (tisp_pkg::QPTR_W+1)'(tisp_pkg::QDEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   // advance pointers and count
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (tisp_pkg::QPTR_W+1)'(do_push) - (tisp_pkg::QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // store the pushed beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wr_entry;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (tisp_pkg::QPTR_W+1)'(tisp_pkg::QDEPTH))
      else $error("queue count beyond depth");

   a_cnt_up: assert property (@(posedge clock) disable iff (reset)
      (push && !full && !(pop && !empty)) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count did not rise on push");

   a_cnt_dn: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !(push && !full)) |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("queue count did not fall on pop");

endmodule
`default_nettype wire

[rtl/tisp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tisp_back: result sequencer
// Delivers the one or two results of each queue entry in order.
// ----------------------------------------------------------------------------
module tisp_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      q_empty,
   input  wire tisp_pkg::entry_type q_head,
   output logic                     q_pop,
   output logic                     empty,
   input  wire                      pop,
   output tisp_pkg::rsp_type        rsp_item
);

   logic sel_ff, sel_in;
   logic take;

   assign empty    = q_empty;
   assign rsp_item = sel_ff ? q_head.r1 : q_head.r0;
   assign take     = pop && !q_empty;
   assign q_pop    = take && (sel_ff || !q_head.two);

   // step to the second result or to the next entry
   always_comb begin
      sel_in = sel_ff;
      if (take) begin
         sel_in = q_head.two && !sel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule
`default_nettype wire

[rtl/terminal_input_sequence_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_input_sequence_parser: terminal byte stream to key/mouse events
// Front parser, four-entry result queue and an output sequencer.
// ----------------------------------------------------------------------------
// Takes one byte or escape-timeout tick per cycle while full is low; the
// parser state updates in the cycle the beat is taken, and its results are
// registered into the queue and reach rsp_item in order. Each beat yields
// zero, one or two results, which wait as one entry in a four-entry queue;
// full rises only when four entries wait. A two-result beat (escape
// followed by a control byte) holds the output for both results, so one
// beat per cycle is sustained while beats yield at most one result and
// pop stays high. Results appear on rsp_item while empty is low and leave on pop.
module terminal_input_sequence_parser (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   output logic                   full,
   input  wire tisp_pkg::req_type req_item,
   output logic                   empty,
   input  wire                    pop,
   output tisp_pkg::rsp_type      rsp_item
);

   logic q_push, q_full, q_pop, q_empty;
   tisp_pkg::entry_type q_entry, q_head;

   tisp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   tisp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .full     (q_full),
      .wr_entry (q_entry),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   tisp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule
`default_nettype wire
